// File: src/qgp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qgp_pkg;

  localparam int QW  = 32;
  localparam int DTW = 24;
  localparam int RW  = 33;
  localparam int SW  = 40;
  localparam int PRW = 65;
  localparam int MW  = 31;
  localparam int RTW = 32;
  localparam int SQW = 64;
  localparam int NUMW = 62;

  localparam logic [DTW-1:0] STEP_TIME_RST = 24'd16777;
  localparam logic [41:0]    NORM_FLOOR_SQ = 42'd1152921;
  localparam logic [QW-1:0]  SAT_POS       = 32'h7FFF_FFFF;
  localparam logic [QW-1:0]  SAT_NEG       = 32'h8000_0000;
  localparam logic           STATUS_OK     = 1'b0;
  localparam logic           STATUS_ERR    = 1'b1;

  typedef logic [MW-1:0] qgp_mag_t;

  typedef struct packed {
    logic [3:0]    neg;
    logic          err;
    logic [QW-1:0] bias_x;
    logic [QW-1:0] bias_y;
  } qgp_side_t;

  typedef struct packed {
    logic [QW-1:0] w;
    logic [QW-1:0] x;
    logic [QW-1:0] y;
    logic [QW-1:0] z;
    logic [QW-1:0] bias_x;
    logic [QW-1:0] bias_y;
    logic          status;
  } qgp_out_t;

  function automatic logic signed [PRW-1:0] rnd_shift(input logic signed [PRW-1:0] x,
                                                      input int unsigned sh);
    logic signed [PRW-1:0] half;
    half = $signed(PRW'(1)) <<< (sh - 1);
    return (x + (x[PRW-1] ? half - $signed(PRW'(1)) : half)) >>> sh;
  endfunction

endpackage
`default_nettype wire

// File: src/qgp_rate.sv
`timescale 1ns / 1ps
`default_nettype none
module qgp_rate import qgp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic signed [QW-1:0]  quat_w,
  input  logic signed [QW-1:0]  quat_x,
  input  logic signed [QW-1:0]  quat_y,
  input  logic signed [QW-1:0]  quat_z,
  input  logic signed [QW-1:0]  bias_x,
  input  logic signed [QW-1:0]  bias_y,
  input  logic signed [QW-1:0]  gyro_x,
  input  logic signed [QW-1:0]  gyro_y,
  input  logic signed [QW-1:0]  gyro_z,
  input  logic [DTW-1:0]        step_time,
  output logic                  p_valid,
  output logic signed [SW-1:0]  p [4],
  output qgp_side_t             p_side
);

  logic                 a_vld, b_vld, c_vld, d_vld, e_vld;
  logic signed [QW-1:0] a_q [4];
  logic signed [QW-1:0] b_q [4];
  logic signed [QW-1:0] c_q [4];
  logic signed [QW-1:0] d_q [4];
  logic signed [RW-1:0] a_rx, a_ry, a_rz;
  logic signed [PRW-1:0] b_pr [12];
  logic signed [SW-1:0]  rr [12];
  logic signed [SW-1:0]  c_s [4];
  logic signed [PRW-1:0] d_pr [4];
  logic signed [SW-1:0]  e_p [4];
  qgp_side_t a_side, b_side, c_side, d_side, e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
    end
  end

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      rr[i] = SW'(rnd_shift(b_pr[i], 26));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_q[0] <= quat_w;
      a_q[1] <= quat_x;
      a_q[2] <= quat_y;
      a_q[3] <= quat_z;
      a_rx   <= $signed({gyro_x[QW-1], gyro_x}) - $signed({bias_x[QW-1], bias_x});
      a_ry   <= $signed({gyro_y[QW-1], gyro_y}) - $signed({bias_y[QW-1], bias_y});
      a_rz   <= $signed({gyro_z[QW-1], gyro_z});
      a_side.neg    <= '0;
      a_side.err    <= (step_time == '0);
      a_side.bias_x <= bias_x;
      a_side.bias_y <= bias_y;

      b_pr[0]  <= a_q[1] * a_rx;
      b_pr[1]  <= a_q[2] * a_ry;
      b_pr[2]  <= a_q[3] * a_rz;
      b_pr[3]  <= a_q[0] * a_rx;
      b_pr[4]  <= a_q[2] * a_rz;
      b_pr[5]  <= a_q[3] * a_ry;
      b_pr[6]  <= a_q[0] * a_ry;
      b_pr[7]  <= a_q[1] * a_rz;
      b_pr[8]  <= a_q[3] * a_rx;
      b_pr[9]  <= a_q[0] * a_rz;
      b_pr[10] <= a_q[1] * a_ry;
      b_pr[11] <= a_q[2] * a_rx;
      b_q    <= a_q;
      b_side <= a_side;

      c_s[0] <= -(rr[0] + rr[1] + rr[2]);
      c_s[1] <= rr[3] + rr[4] - rr[5];
      c_s[2] <= rr[6] - rr[7] + rr[8];
      c_s[3] <= rr[9] + rr[10] - rr[11];
      c_q    <= b_q;
      c_side <= b_side;

      for (int i = 0; i < 4; i++) begin
        d_pr[i] <= c_s[i] * $signed({1'b0, step_time});
      end
      d_q    <= c_q;
      d_side <= c_side;

      for (int i = 0; i < 4; i++) begin
        e_p[i] <= SW'(d_q[i]) + SW'(rnd_shift(d_pr[i], 25));
      end
      e_side <= d_side;
    end
  end

  assign p_valid = e_vld;
  assign p       = e_p;
  assign p_side  = e_side;

endmodule
`default_nettype wire

// File: src/qgp_norm.sv
`timescale 1ns / 1ps
`default_nettype none
module qgp_norm import qgp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 p_valid,
  input  logic signed [SW-1:0] p [4],
  input  qgp_side_t            p_side,
  output logic                 n_valid,
  output qgp_mag_t             n_ms [4],
  output logic [SQW-1:0]       n_sum,
  output qgp_side_t            n_side
);

  logic           f_vld, g_vld, h_vld, i_vld, j_vld;
  logic [SW-1:0]  mag [4];
  logic [SW-1:0]  mx;
  logic [SW-1:0]  f_m [4];
  logic [SW-1:0]  f_mx;
  logic [5:0]     pos;
  logic [SW-1:0]  g_m [4];
  logic [5:0]     g_pos;
  logic           g_small;
  logic [39:0]    g_sq [4];
  logic [41:0]    small_sum;
  logic [SW-1:0]  shifted [4];
  qgp_mag_t       h_ms [4];
  qgp_mag_t       i_ms [4];
  logic [61:0]    i_sq [4];
  qgp_mag_t       j_ms [4];
  logic [SQW-1:0] j_sum;
  qgp_side_t      f_side, g_side, h_side, i_side, j_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      h_vld <= 1'b0;
      i_vld <= 1'b0;
      j_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= p_valid;
      g_vld <= f_vld;
      h_vld <= g_vld;
      i_vld <= h_vld;
      j_vld <= i_vld;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = p[i][SW-1] ? SW'(-p[i]) : SW'(p[i]);
    end
    mx = mag[0];
    for (int i = 1; i < 4; i++) begin
      if (mag[i] > mx) begin
        mx = mag[i];
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < SW; i++) begin
      if (f_mx[i]) begin
        pos = 6'(i);
      end
    end
  end

  always_comb begin
    small_sum = 42'(g_sq[0]) + 42'(g_sq[1]) + 42'(g_sq[2]) + 42'(g_sq[3]);
    for (int i = 0; i < 4; i++) begin
      if (g_pos > 6'd30) begin
        shifted[i] = g_m[i] >> (g_pos - 6'd30);
      end else begin
        shifted[i] = g_m[i] << (6'd30 - g_pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_m  <= mag;
      f_mx <= mx;
      f_side.neg    <= {p[3][SW-1], p[2][SW-1], p[1][SW-1], p[0][SW-1]};
      f_side.err    <= p_side.err;
      f_side.bias_x <= p_side.bias_x;
      f_side.bias_y <= p_side.bias_y;

      g_m     <= f_m;
      g_pos   <= pos;
      g_small <= (f_mx[SW-1:20] == '0);
      for (int i = 0; i < 4; i++) begin
        g_sq[i] <= f_m[i][19:0] * f_m[i][19:0];
      end
      g_side <= f_side;

      for (int i = 0; i < 4; i++) begin
        h_ms[i] <= shifted[i][MW-1:0];
      end
      h_side.neg    <= g_side.neg;
      h_side.err    <= g_side.err || (g_small && (small_sum <= NORM_FLOOR_SQ));
      h_side.bias_x <= g_side.bias_x;
      h_side.bias_y <= g_side.bias_y;

      for (int i = 0; i < 4; i++) begin
        i_sq[i] <= h_ms[i] * h_ms[i];
      end
      i_ms   <= h_ms;
      i_side <= h_side;

      j_sum  <= SQW'(i_sq[0]) + SQW'(i_sq[1]) + SQW'(i_sq[2]) + SQW'(i_sq[3]);
      j_ms   <= i_ms;
      j_side <= i_side;
    end
  end

  assign n_valid = j_vld;
  assign n_ms    = j_ms;
  assign n_sum   = j_sum;
  assign n_side  = j_side;

endmodule
`default_nettype wire

// File: src/qgp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module qgp_sqrt import qgp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           n_valid,
  input  logic [SQW-1:0] n_sum,
  input  qgp_mag_t       n_ms [4],
  input  qgp_side_t      n_side,
  output logic           s_valid,
  output logic [RTW-1:0] s_root,
  output qgp_mag_t       s_ms [4],
  output qgp_side_t      s_side
);

  localparam int NST = RTW;

  logic           st_vld  [NST];
  logic [RTW-1:0] st_root [NST];
  logic [34:0]    st_rem  [NST];
  logic [SQW-1:0] st_rad  [NST];
  qgp_mag_t       st_ms   [NST][4];
  qgp_side_t      st_side [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic           vld_in;
    logic [RTW-1:0] root_in;
    logic [34:0]    rem_in;
    logic [SQW-1:0] rad_in;
    qgp_mag_t       ms_in [4];
    qgp_side_t      side_in;
    logic [34:0]    rem_sh;
    logic [34:0]    trial;

    if (k == 0) begin : g_first
      assign vld_in  = n_valid;
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = n_sum;
      assign ms_in   = n_ms;
      assign side_in = n_side;
    end else begin : g_next
      assign vld_in  = st_vld[k-1];
      assign root_in = st_root[k-1];
      assign rem_in  = st_rem[k-1];
      assign rad_in  = st_rad[k-1];
      assign ms_in   = st_ms[k-1];
      assign side_in = st_side[k-1];
    end

    assign rem_sh = {rem_in[32:0], rad_in[SQW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[k] <= 1'b0;
      end else if (adv) begin
        st_vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_sh >= trial) begin
          st_rem[k]  <= rem_sh - trial;
          st_root[k] <= {root_in[RTW-2:0], 1'b1};
        end else begin
          st_rem[k]  <= rem_sh;
          st_root[k] <= {root_in[RTW-2:0], 1'b0};
        end
        st_rad[k]  <= {rad_in[SQW-3:0], 2'b00};
        st_ms[k]   <= ms_in;
        st_side[k] <= side_in;
      end
    end
  end

  assign s_valid = st_vld[NST-1];
  assign s_root  = st_root[NST-1];
  assign s_ms    = st_ms[NST-1];
  assign s_side  = st_side[NST-1];

endmodule
`default_nettype wire

// File: src/qgp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module qgp_div import qgp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           s_valid,
  input  logic [RTW-1:0] s_root,
  input  qgp_mag_t       s_ms [4],
  input  qgp_side_t      s_side,
  output logic           d_valid,
  output logic [QW-1:0]  d_quo [4],
  output qgp_side_t      d_side
);

  localparam int NST = QW;

  logic            n_vld;
  logic [NUMW-1:0] n_num [4];
  logic [RTW-1:0]  n_root;
  qgp_side_t       n_side;

  logic           st_vld  [NST];
  logic [RTW:0]   st_rem  [NST][4];
  logic [31:0]    st_low  [NST][4];
  logic [QW-1:0]  st_quo  [NST][4];
  logic [RTW-1:0] st_root [NST];
  qgp_side_t      st_side [NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (adv) begin
      n_vld <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        n_num[i] <= NUMW'({s_ms[i], 30'd0}) + NUMW'(s_root >> 1);
      end
      n_root <= s_root;
      n_side <= s_side;
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic           vld_in;
    logic [RTW:0]   rem_in [4];
    logic [31:0]    low_in [4];
    logic [QW-1:0]  quo_in [4];
    logic [RTW-1:0] root_in;
    qgp_side_t      side_in;
    logic [RTW:0]   rem_sh [4];

    if (k == 0) begin : g_first
      assign vld_in  = n_vld;
      assign root_in = n_root;
      assign side_in = n_side;
      for (genvar i = 0; i < 4; i++) begin : g_ln
        assign rem_in[i] = (RTW+1)'(n_num[i][NUMW-1:32]);
        assign low_in[i] = n_num[i][31:0];
        assign quo_in[i] = '0;
      end
    end else begin : g_next
      assign vld_in  = st_vld[k-1];
      assign root_in = st_root[k-1];
      assign side_in = st_side[k-1];
      assign rem_in  = st_rem[k-1];
      assign low_in  = st_low[k-1];
      assign quo_in  = st_quo[k-1];
    end

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        rem_sh[i] = {rem_in[i][RTW-1:0], low_in[i][31]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[k] <= 1'b0;
      end else if (adv) begin
        st_vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 4; i++) begin
          if (rem_sh[i] >= {1'b0, root_in}) begin
            st_rem[k][i] <= rem_sh[i] - {1'b0, root_in};
            st_quo[k][i] <= {quo_in[i][QW-2:0], 1'b1};
          end else begin
            st_rem[k][i] <= rem_sh[i];
            st_quo[k][i] <= {quo_in[i][QW-2:0], 1'b0};
          end
          st_low[k][i] <= {low_in[i][30:0], 1'b0};
        end
        st_root[k] <= root_in;
        st_side[k] <= side_in;
      end
    end
  end

  assign d_valid = st_vld[NST-1];
  assign d_quo   = st_quo[NST-1];
  assign d_side  = st_side[NST-1];

endmodule
`default_nettype wire

// File: src/quaternion_gyro_propagate.sv
`timescale 1ns / 1ps
`default_nettype none
// Quaternion gyro propagation: one first-order Hamilton integration step per
// request, followed by renormalization to unit length.
// Input channel: in_valid/in_ready with quaternion, X/Y bias and gyro sample.
// Output channel: out_valid/out_ready with the normalized quaternion, the
// biases unchanged and status (1 when the norm is too small or dt is zero).
// Config: cfg_wen writes cfg_wdata into the step time at once; write it only
// while no request is in flight.
// Pipeline: 5 stages of rate products, 5 of magnitude and normalization, 32 of the
// one-bit-per-stage square root, 33 of the four-lane restoring divider, then the
// output buffer.
// Throughput: one request per cycle while in_ready is high.
// Reset clears all valid bits and loads the step time with its default.
// A stalled receiver freezes the pipeline only once the two-entry output
// buffer is full; until then requests keep entering.
module quaternion_gyro_propagate import qgp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [DTW-1:0]       cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  input  logic signed [QW-1:0] bias_x,
  input  logic signed [QW-1:0] bias_y,
  input  logic signed [QW-1:0] gyro_x,
  input  logic signed [QW-1:0] gyro_y,
  input  logic signed [QW-1:0] gyro_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [QW-1:0] next_w,
  output logic signed [QW-1:0] next_x,
  output logic signed [QW-1:0] next_y,
  output logic signed [QW-1:0] next_z,
  output logic signed [QW-1:0] next_bias_x,
  output logic signed [QW-1:0] next_bias_y,
  output logic                 status
);

  logic           step_time_q;
  logic [DTW-1:0] step_time;
  logic           adv;

  logic                 p_valid;
  logic signed [SW-1:0] p [4];
  qgp_side_t            p_side;
  logic                 n_valid;
  qgp_mag_t             n_ms [4];
  logic [SQW-1:0]       n_sum;
  qgp_side_t            n_side;
  logic                 s_valid;
  logic [RTW-1:0]       s_root;
  qgp_mag_t             s_ms [4];
  qgp_side_t            s_side;
  logic                 d_valid;
  logic [QW-1:0]        d_quo [4];
  qgp_side_t            d_side;

  logic [QW-1:0] res [4];
  qgp_out_t      res_rec;
  qgp_out_t      ent [2];
  logic [1:0]    cnt;
  logic          push, pop;

  assign step_time_q = cfg_wen;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= STEP_TIME_RST;
    end else if (step_time_q) begin
      step_time <= cfg_wdata;
    end
  end

  assign adv      = !d_valid || (cnt != 2'd2) || out_ready;
  assign in_ready = adv;

  qgp_rate u_rate (
    .clk, .rst, .adv, .in_valid,
    .quat_w, .quat_x, .quat_y, .quat_z,
    .bias_x, .bias_y, .gyro_x, .gyro_y, .gyro_z,
    .step_time, .p_valid, .p, .p_side
  );

  qgp_norm u_norm (
    .clk, .rst, .adv, .p_valid, .p, .p_side,
    .n_valid, .n_ms, .n_sum, .n_side
  );

  qgp_sqrt u_sqrt (
    .clk, .rst, .adv, .n_valid, .n_sum, .n_ms, .n_side,
    .s_valid, .s_root, .s_ms, .s_side
  );

  qgp_div u_div (
    .clk, .rst, .adv, .s_valid, .s_root, .s_ms, .s_side,
    .d_valid, .d_quo, .d_side
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (d_side.err) begin
        res[i] = '0;
      end else if (d_side.neg[i]) begin
        res[i] = (d_quo[i] > SAT_NEG) ? SAT_NEG : QW'(-d_quo[i]);
      end else begin
        res[i] = (d_quo[i] > SAT_POS) ? SAT_POS : d_quo[i];
      end
    end
    res_rec.w      = res[0];
    res_rec.x      = res[1];
    res_rec.y      = res[2];
    res_rec.z      = res[3];
    res_rec.bias_x = d_side.bias_x;
    res_rec.bias_y = d_side.bias_y;
    res_rec.status = d_side.err ? STATUS_ERR : STATUS_OK;
  end

  assign push = adv && d_valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          ent[0] <= res_rec;
        end else begin
          ent[1] <= res_rec;
        end
      end
      2'b01: begin
        ent[0] <= ent[1];
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          ent[0] <= res_rec;
        end else begin
          ent[0] <= ent[1];
          ent[1] <= res_rec;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid   = (cnt != 2'd0);
  assign next_w      = ent[0].w;
  assign next_x      = ent[0].x;
  assign next_y      = ent[0].y;
  assign next_z      = ent[0].z;
  assign next_bias_x = ent[0].bias_x;
  assign next_bias_y = ent[0].bias_y;
  assign status      = ent[0].status;

endmodule
`default_nettype wire

// File: src/qgp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module qgp_props import qgp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [QW-1:0] next_w,
  input logic signed [QW-1:0] next_x,
  input logic signed [QW-1:0] next_y,
  input logic signed [QW-1:0] next_z,
  input logic                 status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_w) && $stable(status))
    else $error("stalled output changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> next_w == 0 && next_x == 0 && next_y == 0 && next_z == 0)
    else $error("error result carries a quaternion");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> !(next_w == 0 && next_x == 0 && next_y == 0 && next_z == 0))
    else $error("normalized quaternion is zero");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without a stalled output");

endmodule

bind quaternion_gyro_propagate qgp_props u_qgp_props (.*);
`default_nettype wire

// File: dv/qgp_checker.sv
`timescale 1ns / 1ps
module qgp_checker import qgp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [DTW-1:0]       cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  input  logic signed [QW-1:0] bias_x,
  input  logic signed [QW-1:0] bias_y,
  input  logic signed [QW-1:0] gyro_x,
  input  logic signed [QW-1:0] gyro_y,
  input  logic signed [QW-1:0] gyro_z,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [QW-1:0] next_w,
  input  logic signed [QW-1:0] next_x,
  input  logic signed [QW-1:0] next_y,
  input  logic signed [QW-1:0] next_z,
  input  logic signed [QW-1:0] next_bias_x,
  input  logic signed [QW-1:0] next_bias_y,
  input  logic                 status,
  output int                   errors,
  output int                   pending,
  output int                   results,
  output int                   err_results
);

  typedef logic signed [127:0] wide_t;

  logic [DTW-1:0] dt_model;
  qgp_out_t       attitude_q[$];

  function automatic wide_t round_mul(input wide_t a, input wide_t b, input int sh);
    logic [127:0] m;
    logic         neg;
    neg = (a < 0) != (b < 0);
    m = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    m = (m + (128'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] res, bitv;
    res = 0;
    bitv = 128'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic qgp_out_t propagate(input logic [DTW-1:0] dt_in,
      input logic signed [QW-1:0] qw, qx, qy, qz, bx, by, gx, gy, gz);
    qgp_out_t     o;
    wide_t        rx, ry, rz, dt;
    wide_t        s[4], p[4];
    logic [127:0] m[4], mx, sum, r, v;
    logic         bad;
    rx = wide_t'(gx) - wide_t'(bx);
    ry = wide_t'(gy) - wide_t'(by);
    rz = wide_t'(gz);
    dt = wide_t'({1'b0, dt_in});
    o.bias_x = bx;
    o.bias_y = by;
    s[0] = -(round_mul(qx, rx, 26) + round_mul(qy, ry, 26) + round_mul(qz, rz, 26));
    s[1] = round_mul(qw, rx, 26) + round_mul(qy, rz, 26) - round_mul(qz, ry, 26);
    s[2] = round_mul(qw, ry, 26) - round_mul(qx, rz, 26) + round_mul(qz, rx, 26);
    s[3] = round_mul(qw, rz, 26) + round_mul(qx, ry, 26) - round_mul(qy, rx, 26);
    p[0] = qw; p[1] = qx; p[2] = qy; p[3] = qz;
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      p[i] = p[i] + round_mul(s[i], dt, 25);
      m[i] = p[i] < 0 ? -p[i] : p[i];
      if (m[i] > mx) mx = m[i];
    end
    bad = (dt_in == 0);
    if (mx < (128'd1 << 20)) begin
      sum = 0;
      for (int i = 0; i < 4; i++) sum = sum + m[i] * m[i];
      if (sum <= 128'(NORM_FLOOR_SQ)) bad = 1'b1;
    end
    if (bad) begin
      o.w = 0; o.x = 0; o.y = 0; o.z = 0;
      o.status = STATUS_ERR;
      return o;
    end
    while (mx >= (128'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 4; i++) m[i] = m[i] >> 1;
    end
    while (mx < (128'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 4; i++) m[i] = m[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum = sum + m[i] * m[i];
    r = floor_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      logic [QW-1:0] lane;
      v = ((m[i] << 30) + (r >> 1)) / r;
      if (p[i] < 0) begin
        if (v > 128'h8000_0000) v = 128'h8000_0000;
        lane = QW'(-v);
      end else begin
        if (v > 128'h7FFF_FFFF) v = 128'h7FFF_FFFF;
        lane = QW'(v);
      end
      case (i)
        0: o.w = lane;
        1: o.x = lane;
        2: o.y = lane;
        default: o.z = lane;
      endcase
    end
    o.status = STATUS_OK;
    return o;
  endfunction

  assign pending = attitude_q.size();

  always @(posedge clk) begin
    qgp_out_t exp_o, act_o;
    if (rst) begin
      dt_model <= STEP_TIME_RST;
      errors <= 0;
      results <= 0;
      err_results <= 0;
      attitude_q.delete();
    end else begin
      if (cfg_wen) dt_model <= cfg_wdata;
      if (in_valid && in_ready)
        attitude_q.push_back(propagate(dt_model, quat_w, quat_x, quat_y, quat_z,
                                       bias_x, bias_y, gyro_x, gyro_y, gyro_z));
      if (out_valid && out_ready) begin
        act_o = '{next_w, next_x, next_y, next_z, next_bias_x, next_bias_y, status};
        results <= results + 1;
        if (status == STATUS_ERR) err_results <= err_results + 1;
        if (attitude_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %p", act_o);
          errors <= errors + 1;
        end else begin
          exp_o = attitude_q.pop_front();
          if (exp_o !== act_o) begin
            if (errors < 10) $display("result %0d: expected %p, got %p", results, exp_o, act_o);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import qgp_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic [DTW-1:0]       cfg_wdata;
  logic                 in_valid, in_ready, out_valid, out_ready;
  logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [QW-1:0] bias_x, bias_y, gyro_x, gyro_y, gyro_z;
  logic signed [QW-1:0] next_w, next_x, next_y, next_z, next_bias_x, next_bias_y;
  logic                 status;
  int                   errors, pending, results, err_results;
  int                   sent;
  bit                   quiet, hold_req;

  quaternion_gyro_propagate i_dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .bias_x(bias_x), .bias_y(bias_y),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_w(next_w), .next_x(next_x), .next_y(next_y), .next_z(next_z),
    .next_bias_x(next_bias_x), .next_bias_y(next_bias_y), .status(status)
  );

  qgp_checker i_checker (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .bias_x(bias_x), .bias_y(bias_y),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_w(next_w), .next_x(next_x), .next_y(next_y), .next_z(next_z),
    .next_bias_x(next_bias_x), .next_bias_y(next_bias_y), .status(status),
    .errors(errors), .pending(pending), .results(results), .err_results(err_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("quaternion_gyro_propagate: mismatch");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [QW-1:0] span_val(input int unsigned span);
    return QW'(longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  task automatic offer(input logic [QW-1:0] qw, qx, qy, qz, bx, by, gx, gy, gz);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
    bias_x <= bx; bias_y <= by;
    gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      offer(span_val(32'h3FFF_FFFF), span_val(32'h3FFF_FFFF), span_val(32'h3FFF_FFFF),
            span_val(32'h3FFF_FFFF), span_val(32'h0400_0000), span_val(32'h0400_0000),
            span_val(32'h1000_0000), span_val(32'h1000_0000), span_val(32'h1000_0000));
    else if (pick < 7)
      offer(span_val(1500), span_val(1500), span_val(1500), span_val(1500),
            $urandom, $urandom, span_val(4000), span_val(4000), span_val(4000));
    else
      offer($urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain_and_write(input logic [DTW-1:0] dt);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= dt;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    logic [DTW-1:0] dt_plan[6];
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    {quat_w, quat_x, quat_y, quat_z, bias_x, bias_y, gyro_x, gyro_y, gyro_z} = '0;
    sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(32'h4000_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    offer(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
    offer(1073, 0, 0, 0, 0, 0, 0, 0, 0);
    offer(1074, 0, 0, 0, 0, 0, 0, 0, 0);
    offer(-1074, 0, 0, 0, 0, 0, 0, 0, 0);
    offer(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer(32'h2D41_3CCD, 32'hD2BE_C333, 32'h2D41_3CCD, 32'hD2BE_C333, 32'h0010_0000,
          32'hFFF0_0000, 32'h0400_0000, 32'hFC00_0000, 32'h0800_0000);
    offer(0, 32'h4000_0000, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0);
    offer(0, 0, 32'hC000_0000, 0, 0, 0, 0, 32'h8000_0000, 0);
    offer(0, 0, 0, 32'h4000_0000, 0, 0, 0, 0, 32'h7FFF_FFFF);
    offer(32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 5, 5, 5, 5, 5);

    dt_plan = '{24'd1, 24'hFF_FFFF, 24'd0, 24'd1, 24'hFF_FFFF, 24'd16777};
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        if (ph < 4) drain_and_write(dt_plan[ph - 1]);
        else drain_and_write(ph == 6 ? dt_plan[5] : DTW'($urandom));
      end
      if (ph == 6) quiet = 1'b1;
      for (int k = 0; k < 260; k++) begin
        if (ph == 1 && k == 20) hold_req = 1'b1;
        random_item();
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d requests over 7 step-time settings incl. zero and both extremes,",
             sent);
    $display("checked %0d results, %0d with error status", results, err_results);
    if (errors == 0 && pending == 0) begin
      $display("quaternion_gyro_propagate: match");
    end else begin
      $display("quaternion_gyro_propagate: mismatch");
    end
    $finish;
  end

endmodule
